// ----- design/iphp_pkg.sv -----
package iphp_pkg;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [7:0] PROTO_ICMP = 8'd1;

   localparam logic [1:0] CLASS_TCP     = 2'd0;
   localparam logic [1:0] CLASS_UDP     = 2'd1;
   localparam logic [1:0] CLASS_ICMP    = 2'd2;
   localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

   localparam logic [3:0]  IHL_MASK    = 4'hF;
   localparam logic [15:0] WORD_ONES   = 16'hFFFF;
   localparam logic [15:0] INDEX_MAX   = 16'hFFFF;
   localparam logic [5:0]  MIN_HDR_LEN = 6'd4;

   // one queued action: a summary snapshot or a payload byte
   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic        last;
      logic [5:0]  hdr_len;
      logic [7:0]  tos;
      logic [7:0]  ttl;
      logic [7:0]  proto;
      logic [15:0] total_len;
      logic [15:0] sum;
      logic        pad;
      logic [7:0]  hold;
      logic [31:0] src;
      logic [31:0] dst;
   } entry_type;

   function automatic logic [15:0] fold_add(logic [15:0] acc, logic [15:0] word);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, word};
      return s[15:0] + {15'b0, s[16]};
   endfunction

   function automatic logic [1:0] classify(logic [7:0] p);
      logic [1:0] c;
      case (p)
         PROTO_TCP:  c = CLASS_TCP;
         PROTO_UDP:  c = CLASS_UDP;
         PROTO_ICMP: c = CLASS_ICMP;
         default:    c = CLASS_UNKNOWN;
      endcase
      return c;
   endfunction

endpackage

// ----- design/ipv4_header_parser_unit.sv -----
// a result is written into the queue when the byte that causes it is accepted,
//   then popped into the output register once that register is free or draining
// throughput: one byte per cycle while the queue is not full, limited by the front
//   parser's single byte-wide update of index, captured fields and header checksum
//   each cycle; header and padding bytes that give no result still pass through it
// reset: synchronous, active high; clears parser state, queue and output register
module ipv4_header_parser_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_payload_last,
   output logic [5:0]  rsp_header_len,
   output logic [7:0]  rsp_tos,
   output logic [7:0]  rsp_ttl,
   output logic [7:0]  rsp_protocol,
   output logic [1:0]  rsp_proto_class,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_checksum_ok,
   output logic [31:0] rsp_src_addr,
   output logic [31:0] rsp_dst_addr
);

   logic                q_full;
   logic                q_push;
   iphp_pkg::entry_type q_entry;
   logic                head_valid;
   iphp_pkg::entry_type head_entry;
   logic                q_pop;

   iphp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_frame_end (req_frame_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   iphp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop)
   );

   iphp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_payload_last   (rsp_payload_last),
      .rsp_header_len     (rsp_header_len),
      .rsp_tos            (rsp_tos),
      .rsp_ttl            (rsp_ttl),
      .rsp_protocol       (rsp_protocol),
      .rsp_proto_class    (rsp_proto_class),
      .rsp_payload_length (rsp_payload_length),
      .rsp_checksum_ok    (rsp_checksum_ok),
      .rsp_src_addr       (rsp_src_addr),
      .rsp_dst_addr       (rsp_dst_addr)
   );

endmodule

// ----- design/iphp_front.sv -----
module iphp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_frame_end,
   input  logic                q_full,
   output logic                q_push,
   output iphp_pkg::entry_type q_entry
);

   logic [15:0] byte_index_ff, byte_index_in;
   logic [5:0]  hdr_bytes_ff, hdr_bytes_in;
   logic [7:0]  tos_ff, tos_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] total_len_ff, total_len_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic        sent_ff, sent_in;

   logic        accept;
   logic [15:0] idx;
   logic [7:0]  b;
   logic        ck_en;
   logic [5:0]  hdr_end;
   logic [5:0]  pay_start;
   logic        summ;
   logic        pay;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign idx       = byte_index_ff;
   assign b         = req_in_byte;

   always_comb begin
      hdr_bytes_in = hdr_bytes_ff;
      tos_in       = tos_ff;
      ttl_in       = ttl_ff;
      proto_in     = proto_ff;
      total_len_in = total_len_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      if (!sent_ff) begin
         if (idx == 16'd0) begin
            hdr_bytes_in = {b[3:0] & iphp_pkg::IHL_MASK, 2'b00};
         end else if (idx == 16'd1) begin
            tos_in = b;
         end else if (idx == 16'd2) begin
            total_len_in = {b, total_len_ff[7:0]};
         end else if (idx == 16'd3) begin
            total_len_in = {total_len_ff[15:8], b};
         end else if (idx == 16'd8) begin
            ttl_in = b;
         end else if (idx == 16'd9) begin
            proto_in = b;
         end else if (idx inside {[16'd12:16'd15]}) begin
            src_in = {src_ff[23:0], b};
         end else if (idx inside {[16'd16:16'd19]}) begin
            dst_in = {dst_ff[23:0], b};
         end
      end

      // header words are folded while the index is inside the header
      ck_en   = !sent_ff && (idx < {10'b0, hdr_bytes_in});
      hold_in = (ck_en && !idx[0]) ? b : hold_ff;
      sum_in  = (ck_en && idx[0]) ? iphp_pkg::fold_add(sum_ff, {hold_ff, b}) : sum_ff;

      pay_start = (hdr_bytes_in < iphp_pkg::MIN_HDR_LEN) ? iphp_pkg::MIN_HDR_LEN
                                                         : hdr_bytes_in;
      hdr_end   = pay_start - 6'd1;
      summ      = !sent_ff && ((idx >= {10'b0, hdr_end}) || req_frame_end);
      pay       = sent_ff && (idx >= {10'b0, pay_start}) && (idx < total_len_ff);

      sent_in       = sent_ff || summ;
      byte_index_in = (byte_index_ff != iphp_pkg::INDEX_MAX) ? byte_index_ff + 16'd1
                                                             : byte_index_ff;

      q_push            = accept && (summ || pay);
      q_entry.kind      = summ ? iphp_pkg::KIND_SUMMARY : iphp_pkg::KIND_PAYLOAD;
      q_entry.data      = b;
      q_entry.last      = (idx + 16'd1 == total_len_ff) || req_frame_end;
      q_entry.hdr_len   = hdr_bytes_in;
      q_entry.tos       = tos_in;
      q_entry.ttl       = ttl_in;
      q_entry.proto     = proto_in;
      q_entry.total_len = total_len_in;
      q_entry.sum       = sum_in;
      // header length is a multiple of four, so an odd byte count only comes from early end
      q_entry.pad       = ck_en && !idx[0];
      q_entry.hold      = hold_in;
      q_entry.src       = src_in;
      q_entry.dst       = dst_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_frame_end)) begin
         byte_index_ff <= '0;
         hdr_bytes_ff  <= '0;
         tos_ff        <= '0;
         ttl_ff        <= '0;
         proto_ff      <= '0;
         total_len_ff  <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
         sum_ff        <= '0;
         hold_ff       <= '0;
         sent_ff       <= 1'b0;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
         hdr_bytes_ff  <= hdr_bytes_in;
         tos_ff        <= tos_in;
         ttl_ff        <= ttl_in;
         proto_ff      <= proto_in;
         total_len_ff  <= total_len_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         sum_ff        <= sum_in;
         hold_ff       <= hold_in;
         sent_ff       <= sent_in;
      end
   end

`ifndef ASSERT_OFF
   a_fend_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_frame_end) |=> (byte_index_ff == 16'd0) && !sent_ff)
      else $error("frame end did not clear parser state");

   a_payload_after_summary: assert property (@(posedge clock) disable iff (reset)
      (q_push && (q_entry.kind == iphp_pkg::KIND_PAYLOAD)) |-> sent_ff)
      else $error("payload byte queued before header summary");
`endif

endmodule

// ----- design/iphp_queue.sv -----
module iphp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  iphp_pkg::entry_type push_entry,
   output logic                full,
   output logic                head_valid,
   output iphp_pkg::entry_type head_entry,
   input  logic                pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   iphp_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");
`endif

endmodule

// ----- design/iphp_back.sv -----
module iphp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  iphp_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_payload_last,
   output logic [5:0]          rsp_header_len,
   output logic [7:0]          rsp_tos,
   output logic [7:0]          rsp_ttl,
   output logic [7:0]          rsp_protocol,
   output logic [1:0]          rsp_proto_class,
   output logic [15:0]         rsp_payload_length,
   output logic                rsp_checksum_ok,
   output logic [31:0]         rsp_src_addr,
   output logic [31:0]         rsp_dst_addr
);

   logic        valid_ff;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [7:0]  tos_ff, tos_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [1:0]  class_ff, class_in;
   logic [15:0] plen_ff, plen_in;
   logic        ok_ff, ok_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;

   logic        is_summ;
   logic [15:0] sum_final;
   logic [15:0] hlen_ext;

   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      is_summ   = (head_entry.kind == iphp_pkg::KIND_SUMMARY);
      // pending odd header byte goes in as a high byte padded with zero
      sum_final = head_entry.pad ? iphp_pkg::fold_add(head_entry.sum, {head_entry.hold, 8'h00})
                                 : head_entry.sum;
      hlen_ext  = {10'b0, head_entry.hdr_len};

      kind_in  = head_entry.kind;
      byte_in  = is_summ ? 8'h00 : head_entry.data;
      last_in  = !is_summ && head_entry.last;
      hlen_in  = '0;
      tos_in   = '0;
      ttl_in   = '0;
      proto_in = '0;
      class_in = '0;
      plen_in  = '0;
      ok_in    = 1'b0;
      src_in   = '0;
      dst_in   = '0;
      if (is_summ) begin
         hlen_in  = head_entry.hdr_len;
         tos_in   = head_entry.tos;
         ttl_in   = head_entry.ttl;
         proto_in = head_entry.proto;
         class_in = iphp_pkg::classify(head_entry.proto);
         plen_in  = (head_entry.total_len > hlen_ext) ? head_entry.total_len - hlen_ext
                                                      : 16'd0;
         ok_in    = (sum_final == iphp_pkg::WORD_ONES);
         src_in   = head_entry.src;
         dst_in   = head_entry.dst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         last_ff  <= last_in;
         hlen_ff  <= hlen_in;
         tos_ff   <= tos_in;
         ttl_ff   <= ttl_in;
         proto_ff <= proto_in;
         class_ff <= class_in;
         plen_ff  <= plen_in;
         ok_ff    <= ok_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_payload_last   = last_ff;
   assign rsp_header_len     = hlen_ff;
   assign rsp_tos            = tos_ff;
   assign rsp_ttl            = ttl_ff;
   assign rsp_protocol       = proto_ff;
   assign rsp_proto_class    = class_ff;
   assign rsp_payload_length = plen_ff;
   assign rsp_checksum_ok    = ok_ff;
   assign rsp_src_addr       = src_ff;
   assign rsp_dst_addr       = dst_ff;

`ifndef ASSERT_OFF
   a_payload_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == iphp_pkg::KIND_PAYLOAD)) |->
         (rsp_header_len == 6'd0) && (rsp_payload_length == 16'd0) && !rsp_checksum_ok)
      else $error("payload transfer carries summary fields");
`endif

endmodule
